FILE: rtl/core/dllc_pkg.sv
// Shared types, sizes and command codes for the linked-list cursor core.
// No dependencies; used by the core and the port checker.
`default_nettype none

package dllc_pkg;

    // pool size and stored word width
    localparam int NODES      = 16;
    localparam int DATA_WIDTH = 32;

    // port field widths
    localparam int CMD_W = 4;
    localparam int IN_W  = 32;
    localparam int OUT_W = 32;

    // node address, node index (one more code for null) and kept word width
    localparam int AW = $clog2(NODES);
    localparam int IW = $clog2(NODES + 1);
    localparam int SW = (DATA_WIDTH < IN_W) ? DATA_WIDTH : IN_W;

    localparam logic [IW-1:0] NIL = IW'(NODES);

    typedef enum logic [CMD_W-1:0] {
        CMD_FIRST       = 4'd0,
        CMD_NEXT        = 4'd1,
        CMD_LAST        = 4'd2,
        CMD_PREV        = 4'd3,
        CMD_PUSH_FRONT  = 4'd4,
        CMD_PUSH_BACK   = 4'd5,
        CMD_PUSH_AFTER  = 4'd6,
        CMD_POP_FRONT   = 4'd7,
        CMD_POP_BACK    = 4'd8,
        CMD_POP_CURSOR  = 4'd9,
        CMD_CLEAR       = 4'd10
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    function automatic logic is_node(input logic [IW-1:0] idx);
        return idx < NIL;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dllc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds node words, links and the free-node stack.
`default_nettype none

module dllc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/doubly_linked_list_cursor_core.sv
// Top level of the linked-list cursor core: sequencer around four node RAMs.
// Depends on dllc_pkg and dllc_ram.
`default_nettype none

// One request in, one result out. A request is taken only while the core is
// idle; it passes through S_EVAL and S_DONE, and its result is written into
// the output register as the core leaves S_DONE for idle, where the next
// request can be taken. Next and prev that reach a node also pass through
// S_FETCH (link read, then word read); push_front or push_back onto a
// non-empty list and a push after a live node also pass through S_LINK (the
// neighbour's link is rewritten in a second write on the link RAMs). Every
// RAM has a registered read port. A result waiting at the output does not
// block the next request, only the following hand-over. Node RAMs need no
// initialisation after reset: every node is written when it is allocated.
module doubly_linked_list_cursor_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [dllc_pkg::IN_W-1:0] s_tdata,   // [31:0] data_in
    input  wire logic [dllc_pkg::CMD_W-1:0] s_tuser,  // [3:0] command
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [dllc_pkg::OUT_W-1:0]     m_tdata,   // [31:0] data_out
    output logic [2:0]                     m_tuser    // [0] has_data, [2:1] status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_FETCH,
        S_LINK,
        S_DONE
    } state_t;

    localparam int AW = dllc_pkg::AW;
    localparam int IW = dllc_pkg::IW;
    localparam int DW = dllc_pkg::DATA_WIDTH;
    localparam int SW = dllc_pkg::SW;

    state_t                   state_reg, state_next;
    dllc_pkg::cmd_t           cmd_reg, cmd_next;
    logic [SW-1:0]            word_reg, word_next;
    logic [IW-1:0]            subj_reg, subj_next;
    logic [IW-1:0]            node_reg, node_next;
    logic [IW-1:0]            link_reg, link_next;
    logic [IW-1:0]            head_reg, head_next;
    logic [IW-1:0]            tail_reg, tail_next;
    logic [IW-1:0]            cursor_reg, cursor_next;
    logic [IW-1:0]            fresh_reg, fresh_next;
    logic [IW-1:0]            free_depth_reg, free_depth_next;
    logic [dllc_pkg::OUT_W-1:0] res_data_reg, res_data_next;
    logic                     res_has_reg, res_has_next;
    dllc_pkg::status_t        res_status_reg, res_status_next;
    logic                     out_valid_reg, out_valid_next;
    logic [dllc_pkg::OUT_W-1:0] out_data_reg, out_data_next;
    logic                     out_has_reg, out_has_next;
    dllc_pkg::status_t        out_status_reg, out_status_next;

    // RAM ports
    logic          d_we, n_we, p_we, f_we;
    logic [AW-1:0] d_waddr, n_waddr, p_waddr, f_waddr;
    logic [AW-1:0] d_raddr, n_raddr, p_raddr, f_raddr;
    logic [DW-1:0] d_wdata, d_rdata;
    logic [IW-1:0] n_wdata, n_rdata, p_wdata, p_rdata;
    logic [AW-1:0] f_wdata, f_rdata;

    dllc_pkg::cmd_t cmd_in;
    logic [IW-1:0]  subj_sel;
    logic [IW-1:0]  alloc_idx;
    logic [IW-1:0]  step_idx;
    logic           pool_full;
    logic           subj_ok;

    dllc_ram #(.WIDTH(DW), .DEPTH(dllc_pkg::NODES)) u_data_ram (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    dllc_ram #(.WIDTH(IW), .DEPTH(dllc_pkg::NODES)) u_next_ram (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    dllc_ram #(.WIDTH(IW), .DEPTH(dllc_pkg::NODES)) u_prev_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    dllc_ram #(.WIDTH(AW), .DEPTH(dllc_pkg::NODES)) u_free_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    assign cmd_in    = dllc_pkg::cmd_t'(s_tuser);
    assign alloc_idx = (free_depth_reg != '0) ? IW'(f_rdata) : fresh_reg;
    assign pool_full = (free_depth_reg == '0) && (fresh_reg >= dllc_pkg::NIL);
    assign subj_ok   = dllc_pkg::is_node(subj_reg);
    assign step_idx  = (cmd_reg == dllc_pkg::CMD_NEXT) ? n_rdata : p_rdata;

    // node each command starts from
    always_comb
    begin
        unique case (cmd_in) inside
            dllc_pkg::CMD_FIRST, dllc_pkg::CMD_PUSH_FRONT, dllc_pkg::CMD_POP_FRONT:
                subj_sel = head_reg;
            dllc_pkg::CMD_LAST, dllc_pkg::CMD_PUSH_BACK, dllc_pkg::CMD_POP_BACK:
                subj_sel = tail_reg;
            dllc_pkg::CMD_NEXT, dllc_pkg::CMD_PREV, dllc_pkg::CMD_PUSH_AFTER,
            dllc_pkg::CMD_POP_CURSOR:
                subj_sel = cursor_reg;
            default:
                subj_sel = dllc_pkg::NIL;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        word_next       = word_reg;
        subj_next       = subj_reg;
        node_next       = node_reg;
        link_next       = link_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cursor_next     = cursor_reg;
        fresh_next      = fresh_reg;
        free_depth_next = free_depth_reg;
        res_data_next   = res_data_reg;
        res_has_next    = res_has_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_has_next    = out_has_reg;
        out_status_next = out_status_reg;

        d_we    = 1'b0;
        n_we    = 1'b0;
        p_we    = 1'b0;
        f_we    = 1'b0;
        d_waddr = node_reg[AW-1:0];
        n_waddr = node_reg[AW-1:0];
        p_waddr = node_reg[AW-1:0];
        f_waddr = AW'(free_depth_reg);
        d_wdata = DW'(word_reg);
        n_wdata = dllc_pkg::NIL;
        p_wdata = dllc_pkg::NIL;
        f_wdata = subj_reg[AW-1:0];
        d_raddr = subj_sel[AW-1:0];
        n_raddr = subj_sel[AW-1:0];
        p_raddr = subj_sel[AW-1:0];
        f_raddr = AW'(free_depth_reg - 1'b1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = cmd_in;
                    word_next  = s_tdata[SW-1:0];
                    subj_next  = subj_sel;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                res_data_next   = '0;
                res_has_next    = 1'b0;
                res_status_next = dllc_pkg::ST_OK;
                state_next      = S_DONE;
                d_raddr         = step_idx[AW-1:0];

                unique case (cmd_reg) inside
                    dllc_pkg::CMD_FIRST, dllc_pkg::CMD_LAST:
                    begin
                        if (subj_ok)
                        begin
                            cursor_next   = subj_reg;
                            res_data_next = dllc_pkg::OUT_W'(d_rdata[SW-1:0]);
                            res_has_next  = 1'b1;
                        end
                        else
                        begin
                            res_status_next = dllc_pkg::ST_EMPTY;
                        end
                    end

                    dllc_pkg::CMD_NEXT, dllc_pkg::CMD_PREV:
                    begin
                        if (subj_ok && dllc_pkg::is_node(step_idx))
                        begin
                            cursor_next = step_idx;
                            state_next  = S_FETCH;
                        end
                        else
                        begin
                            res_status_next = dllc_pkg::ST_EMPTY;
                        end
                    end

                    dllc_pkg::CMD_PUSH_FRONT:
                    begin
                        if (pool_full)
                        begin
                            res_status_next = dllc_pkg::ST_FULL;
                        end
                        else
                        begin
                            node_next = alloc_idx;
                            d_we      = 1'b1;
                            n_we      = 1'b1;
                            p_we      = 1'b1;
                            d_waddr   = alloc_idx[AW-1:0];
                            n_waddr   = alloc_idx[AW-1:0];
                            p_waddr   = alloc_idx[AW-1:0];
                            n_wdata   = head_reg;
                            head_next = alloc_idx;
                            link_next = head_reg;
                            if (free_depth_reg != '0)
                                free_depth_next = free_depth_reg - 1'b1;
                            else
                                fresh_next = fresh_reg + 1'b1;
                            if (dllc_pkg::is_node(head_reg))
                                state_next = S_LINK;
                            else
                                tail_next = alloc_idx;
                        end
                    end

                    dllc_pkg::CMD_PUSH_BACK, dllc_pkg::CMD_PUSH_AFTER:
                    begin
                        if (cmd_reg == dllc_pkg::CMD_PUSH_AFTER && !subj_ok)
                        begin
                            res_status_next = dllc_pkg::ST_EMPTY;
                        end
                        else if (pool_full)
                        begin
                            res_status_next = dllc_pkg::ST_FULL;
                        end
                        else
                        begin
                            cursor_next = subj_reg;
                            node_next   = alloc_idx;
                            d_we        = 1'b1;
                            n_we        = 1'b1;
                            p_we        = 1'b1;
                            d_waddr     = alloc_idx[AW-1:0];
                            n_waddr     = alloc_idx[AW-1:0];
                            p_waddr     = alloc_idx[AW-1:0];
                            if (free_depth_reg != '0)
                                free_depth_next = free_depth_reg - 1'b1;
                            else
                                fresh_next = fresh_reg + 1'b1;
                            if (subj_ok)
                            begin
                                // splice between subject and its old successor
                                n_wdata    = n_rdata;
                                p_wdata    = subj_reg;
                                link_next  = n_rdata;
                                state_next = S_LINK;
                                if (!dllc_pkg::is_node(n_rdata))
                                    tail_next = alloc_idx;
                            end
                            else
                            begin
                                head_next = alloc_idx;
                                tail_next = alloc_idx;
                            end
                        end
                    end

                    dllc_pkg::CMD_POP_FRONT, dllc_pkg::CMD_POP_BACK,
                    dllc_pkg::CMD_POP_CURSOR:
                    begin
                        cursor_next = subj_reg;
                        if (subj_ok)
                        begin
                            res_data_next = dllc_pkg::OUT_W'(d_rdata[SW-1:0]);
                            res_has_next  = 1'b1;
                            cursor_next   = n_rdata;
                            n_waddr       = p_rdata[AW-1:0];
                            n_wdata       = n_rdata;
                            p_waddr       = n_rdata[AW-1:0];
                            p_wdata       = p_rdata;
                            if (dllc_pkg::is_node(p_rdata))
                                n_we = 1'b1;
                            else
                                head_next = n_rdata;
                            if (dllc_pkg::is_node(n_rdata))
                                p_we = 1'b1;
                            else
                                tail_next = p_rdata;
                            if (free_depth_reg < dllc_pkg::NIL)
                            begin
                                f_we            = 1'b1;
                                free_depth_next = free_depth_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            res_status_next = dllc_pkg::ST_EMPTY;
                        end
                    end

                    dllc_pkg::CMD_CLEAR:
                    begin
                        head_next       = dllc_pkg::NIL;
                        tail_next       = dllc_pkg::NIL;
                        cursor_next     = dllc_pkg::NIL;
                        fresh_next      = '0;
                        free_depth_next = '0;
                    end

                    default:
                    begin
                    end
                endcase
            end

            S_FETCH:
            begin
                res_data_next = dllc_pkg::OUT_W'(d_rdata[SW-1:0]);
                res_has_next  = 1'b1;
                state_next    = S_DONE;
            end

            S_LINK:
            begin
                // second link write: old neighbours now point at the new node
                n_waddr    = subj_reg[AW-1:0];
                n_wdata    = node_reg;
                n_we       = (cmd_reg != dllc_pkg::CMD_PUSH_FRONT);
                p_waddr    = link_reg[AW-1:0];
                p_wdata    = node_reg;
                p_we       = dllc_pkg::is_node(link_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_data_reg;
                    out_has_next    = res_has_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= dllc_pkg::CMD_CLEAR;
            word_reg       <= '0;
            subj_reg       <= dllc_pkg::NIL;
            node_reg       <= dllc_pkg::NIL;
            link_reg       <= dllc_pkg::NIL;
            head_reg       <= dllc_pkg::NIL;
            tail_reg       <= dllc_pkg::NIL;
            cursor_reg     <= dllc_pkg::NIL;
            fresh_reg      <= '0;
            free_depth_reg <= '0;
            res_data_reg   <= '0;
            res_has_reg    <= 1'b0;
            res_status_reg <= dllc_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_has_reg    <= 1'b0;
            out_status_reg <= dllc_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            word_reg       <= word_next;
            subj_reg       <= subj_next;
            node_reg       <= node_next;
            link_reg       <= link_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cursor_reg     <= cursor_next;
            fresh_reg      <= fresh_next;
            free_depth_reg <= free_depth_next;
            res_data_reg   <= res_data_next;
            res_has_reg    <= res_has_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_has_reg    <= out_has_next;
            out_status_reg <= out_status_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_status_reg, out_has_reg};

endmodule

`default_nettype wire

FILE: rtl/core/dllc_checker.sv
// Port-level checker for the linked-list cursor core, bound to the top level.
// Depends on dllc_pkg and doubly_linked_list_cursor_core.
`default_nettype none

module dllc_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [dllc_pkg::OUT_W-1:0] m_tdata,
    input wire logic [2:0]                 m_tuser
);

    // a cycle held in reset leaves no result offered
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a refused or empty request carries no word
    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:1] != dllc_pkg::ST_OK) |-> !m_tuser[0] && (m_tdata == '0))
        else $error("failed request returned data");

    // one request at a time: taking a request closes the input
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

endmodule

bind doubly_linked_list_cursor_core dllc_checker u_dllc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
